@@ sv/assert_macros.svh @@
// Assertion macros for the timeout queue RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define DLTQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define DLTQ_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

@@ sv/dltq_pkg.sv @@
// Shared types and constants of the delta-list timeout queue.
// Depends on nothing; used by every module of the block.
`default_nettype none
package dltq_pkg;
  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 16;
  localparam int TIME_BITS   = 24;
  localparam int MAX_RESULTS = 16;
  localparam int IW          = $clog2(DEPTH + 1);
  localparam int IX          = $clog2(DEPTH);
  localparam int PW          = $clog2(MAX_RESULTS + 1);
  localparam logic [TIME_BITS-1:0] IDLE_RESET = TIME_BITS'(10000);
  localparam logic [TIME_BITS-1:0] TIME_ONE   = TIME_BITS'(1);

  typedef enum logic [1:0] {
    OP_TICK, OP_ADD, OP_CANCEL, OP_REJECT
  } op_t;

  typedef enum logic [2:0] {
    K_ADDED, K_REJECTED, K_CANCELLED, K_NOT_FOUND, K_EXPIRED, K_NONE
  } kind_t;

  typedef struct packed {
    op_t                    op;
    logic [TIME_BITS-1:0]   amount;
    logic [HANDLE_BITS-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [IW-1:0] count;
  } status_t;
endpackage
`default_nettype wire

@@ sv/delta_list_timeout_queue_core.sv @@
// Top level of the delta-list timeout queue: front queue, back sequencer,
// idle_sleep register and assertions. Depends on dltq_pkg, dltq_front,
// dltq_back and assert_macros.svh.
//
//   channel   handshake            payload
//   command   start / busy         action, amount, handle
//   result    done (one cycle)     kind, result_handle, sleep_hint, last
//   config    cfg_we               cfg_data (idle_sleep)
//
// An accepted add or a cancel goes from S_IDLE to the walk state of the
// back sequencer, which walks one list entry per cycle, and then to S_FIN.
// A tick walks likewise, then pops expiries in S_POP or ends in S_FIN.
// The two-word command queue accepts words while the back end works; busy
// is high only when it is full. Reset is synchronous and empties the list;
// results cannot be held off by the receiver.
`default_nettype none
`include "assert_macros.svh"
module delta_list_timeout_queue_core (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  output logic                              busy,
  input  wire [1:0]                         action,
  input  wire [dltq_pkg::TIME_BITS-1:0]     amount,
  input  wire [dltq_pkg::HANDLE_BITS-1:0]   handle,
  input  wire                               cfg_we,
  input  wire [23:0]                        cfg_data,
  output logic                              done,
  output logic [2:0]                        kind,
  output logic [dltq_pkg::HANDLE_BITS-1:0]  result_handle,
  output logic [dltq_pkg::TIME_BITS-1:0]    sleep_hint,
  output logic                              last
);
  logic [dltq_pkg::TIME_BITS-1:0] idle_sleep;
  logic                          cmd_valid, cmd_pop;
  dltq_pkg::cmd_t                cmd;
  dltq_pkg::kind_t               out_kind;
  dltq_pkg::status_t             status;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_sleep <= dltq_pkg::IDLE_RESET;
    end else if (cfg_we) begin
      idle_sleep <= dltq_pkg::TIME_BITS'(cfg_data);
    end
  end

  dltq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .amount    (amount),
    .handle    (handle),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  dltq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .idle_sleep (idle_sleep),
    .done       (done),
    .out_kind   (out_kind),
    .out_handle (result_handle),
    .out_hint   (sleep_hint),
    .out_last   (last),
    .status     (status)
  );

  assign kind = out_kind;

  `DLTQ_ASSERT_ALWAYS(a_count_bound, int'(status.count) <= dltq_pkg::DEPTH)
  `DLTQ_ASSERT_IMPLY(a_hint_nonzero, done, sleep_hint != '0)
  `DLTQ_ASSERT_IMPLY(a_single_last, done && out_kind != dltq_pkg::K_EXPIRED, last)
endmodule
`default_nettype wire

@@ sv/dltq_front.sv @@
// Front end: takes command words, classifies them and holds them in a
// two-word queue for the back end. Depends on dltq_pkg.
`default_nettype none
module dltq_front (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  input  wire [1:0]                         action,
  input  wire [dltq_pkg::TIME_BITS-1:0]     amount,
  input  wire [dltq_pkg::HANDLE_BITS-1:0]   handle,
  output logic                              busy,
  output logic                              cmd_valid,
  output dltq_pkg::cmd_t                    cmd,
  input  wire                               cmd_pop
);
  dltq_pkg::cmd_t q [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     cnt;
  dltq_pkg::cmd_t cls;
  logic           push, pop;

  always_comb begin
    cls.amount = amount;
    cls.handle = handle;
    case (action)
      2'd0:    cls.op = dltq_pkg::OP_TICK;
      2'd1:    cls.op = (amount == '0) ? dltq_pkg::OP_REJECT : dltq_pkg::OP_ADD;
      2'd2:    cls.op = dltq_pkg::OP_CANCEL;
      default: cls.op = dltq_pkg::OP_REJECT;
    endcase
  end

  assign busy      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = start && !busy;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ sv/dltq_back.sv @@
// Back end: sequencer that walks the delta list and issues result words.
// Depends on dltq_pkg.
`default_nettype none
module dltq_back (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cmd_valid,
  input  dltq_pkg::cmd_t                    cmd,
  output logic                              cmd_pop,
  input  wire [dltq_pkg::TIME_BITS-1:0]     idle_sleep,
  output logic                              done,
  output dltq_pkg::kind_t                   out_kind,
  output logic [dltq_pkg::HANDLE_BITS-1:0]  out_handle,
  output logic [dltq_pkg::TIME_BITS-1:0]    out_hint,
  output logic                              out_last,
  output dltq_pkg::status_t                 status
);
  localparam int D  = dltq_pkg::DEPTH;
  localparam int TB = dltq_pkg::TIME_BITS;
  localparam int HB = dltq_pkg::HANDLE_BITS;
  localparam int IW = dltq_pkg::IW;
  localparam int IX = dltq_pkg::IX;
  localparam int PW = dltq_pkg::PW;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD_WALK, S_CAN_WALK, S_TICK_WALK, S_POP, S_FIN
  } state_t;

  state_t          state;
  logic [TB-1:0]   delta [D];
  logic [HB-1:0]   hstore [D];
  logic [IW-1:0]   count;
  logic [IW-1:0]   idx;
  logic [TB-1:0]   rem;
  logic [HB-1:0]   next_handle;
  logic [HB-1:0]   cur_handle;
  dltq_pkg::kind_t cur_kind;
  logic [PW-1:0]   pops;
  logic [TB-1:0]   hint;

  logic [TB-1:0]   rd_delta;
  logic [HB-1:0]   rd_handle;
  logic            in_range;
  logic [TB-1:0]   up_d [D];
  logic [HB-1:0]   up_h [D];
  logic [TB-1:0]   dn_d [D];
  logic [HB-1:0]   dn_h [D];
  logic [TB:0]     fold_sum;
  logic [TB-1:0]   fold_sat;
  logic [TB-1:0]   hint_now;
  logic [PW-1:0]   n_exp;
  logic [TB-1:0]   tick_raw;
  logic [TB-1:0]   tick_hint;

  assign status.count = count;
  assign in_range  = (idx < count);
  assign rd_delta  = delta[idx[IX-1:0]];
  assign rd_handle = hstore[idx[IX-1:0]];

  always_comb begin
    for (int j = 0; j < D - 1; j++) begin
      up_d[j]     = delta[j+1];
      up_h[j]     = hstore[j+1];
      dn_d[j+1]   = delta[j];
      dn_h[j+1]   = hstore[j];
    end
    up_d[D-1] = delta[D-1];
    up_h[D-1] = hstore[D-1];
    dn_d[0]   = delta[0];
    dn_h[0]   = hstore[0];
  end

  // Cancel folds the removed delta into the successor, saturating.
  assign fold_sum = {1'b0, up_d[idx[IX-1:0]]} + {1'b0, rd_delta};
  assign fold_sat = fold_sum[TB] ? {TB{1'b1}} : fold_sum[TB-1:0];

  always_comb begin
    logic [TB-1:0] v;
    v = (count != '0) ? delta[0] : idle_sleep;
    hint_now = (v == '0) ? dltq_pkg::TIME_ONE : v;
  end

  // Hint after a tick, worked out before the expired entries are popped.
  always_comb begin
    n_exp = (int'(idx) > dltq_pkg::MAX_RESULTS) ? PW'(dltq_pkg::MAX_RESULTS)
                                                 : PW'(idx);
    if (int'(n_exp) < int'(count)) begin
      tick_raw = (int'(n_exp) < int'(idx)) ? '0 : (rd_delta - rem);
    end else begin
      tick_raw = idle_sleep;
    end
    tick_hint = (tick_raw == '0) ? dltq_pkg::TIME_ONE : tick_raw;
  end

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          idx        <= '0;
          rem        <= cmd.amount;
          cur_handle <= cmd.handle;
          case (cmd.op)
            dltq_pkg::OP_TICK:   state <= S_TICK_WALK;
            dltq_pkg::OP_CANCEL: state <= S_CAN_WALK;
            dltq_pkg::OP_ADD: begin
              if (int'(count) >= D) begin
                cur_kind   <= dltq_pkg::K_REJECTED;
                cur_handle <= '0;
                state      <= S_FIN;
              end else begin
                state <= S_ADD_WALK;
              end
            end
            default: begin
              cur_kind   <= dltq_pkg::K_REJECTED;
              cur_handle <= '0;
              state      <= S_FIN;
            end
          endcase
        end
      end
      S_ADD_WALK: begin
        if (in_range && rd_delta <= rem) begin
          rem <= rem - rd_delta;
          idx <= idx + 1'b1;
        end else begin
          for (int j = 0; j < D; j++) begin
            if (IW'(j) > idx) begin
              delta[j]  <= dn_d[j];
              hstore[j] <= dn_h[j];
            end
            if (IW'(j) == idx) begin
              delta[j]  <= rem;
              hstore[j] <= next_handle;
            end
          end
          // The old entry at the insertion point moves up and loses the delay.
          if (in_range) delta[idx[IX-1:0] + 1'b1] <= rd_delta - rem;
          count       <= count + 1'b1;
          cur_handle  <= next_handle;
          next_handle <= next_handle + 1'b1;
          cur_kind    <= dltq_pkg::K_ADDED;
          state       <= S_FIN;
        end
      end
      S_CAN_WALK: begin
        if (!in_range) begin
          cur_kind   <= dltq_pkg::K_NOT_FOUND;
          cur_handle <= '0;
          state      <= S_FIN;
        end else if (rd_handle == cur_handle) begin
          for (int j = 0; j < D; j++) begin
            if (IW'(j) >= idx) begin
              delta[j]  <= up_d[j];
              hstore[j] <= up_h[j];
            end
          end
          if (idx + 1'b1 < count) delta[idx[IX-1:0]] <= fold_sat;
          count    <= count - 1'b1;
          cur_kind <= dltq_pkg::K_CANCELLED;
          state    <= S_FIN;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      S_TICK_WALK: begin
        if (in_range && rd_delta <= rem) begin
          rem <= rem - rd_delta;
          idx <= idx + 1'b1;
        end else begin
          for (int j = 0; j < D; j++) begin
            if (IW'(j) < idx) delta[j] <= '0;
          end
          if (in_range) delta[idx[IX-1:0]] <= rd_delta - rem;
          hint <= tick_hint;
          pops <= n_exp;
          if (n_exp == '0) begin
            cur_kind   <= dltq_pkg::K_NONE;
            cur_handle <= '0;
            state      <= S_FIN;
          end else begin
            state <= S_POP;
          end
        end
      end
      S_POP: begin
        done       <= 1'b1;
        out_kind   <= dltq_pkg::K_EXPIRED;
        out_handle <= hstore[0];
        out_hint   <= hint;
        out_last   <= (pops == PW'(1));
        for (int j = 0; j < D; j++) begin
          delta[j]  <= up_d[j];
          hstore[j] <= up_h[j];
        end
        count <= count - 1'b1;
        pops  <= pops - 1'b1;
        if (pops == PW'(1)) state <= S_IDLE;
      end
      S_FIN: begin
        done       <= 1'b1;
        out_kind   <= cur_kind;
        out_handle <= cur_handle;
        out_hint   <= hint_now;
        out_last   <= 1'b1;
        state      <= S_IDLE;
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      count       <= '0;
      next_handle <= '0;
    end
  end
endmodule
`default_nettype wire
